// ===== rtl/tmsr_pkg.sv =====
// Package for the typed mailbox with selective receive.
// Holds sizes, payload structs, controller state and command types.
// No dependencies.
`default_nettype none
package tmsr_pkg;

  localparam int DEPTH     = 128;
  localparam int BODY_BITS = 64;
  localparam int TYPE_BITS = 12;

  localparam int AW      = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int NTYPES  = 1 << TYPE_BITS;
  localparam int ENTRY_W = TYPE_BITS + 32 + BODY_BITS;

  localparam logic [7:0]  THRESHOLD_RESET = 8'd100;
  localparam logic [15:0] MAX_AGE_RESET   = 16'd10;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MAX_AGE   = 2'd1,
    REG_FLUSH     = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  typedef enum logic {
    MODE_ARRIVE  = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_e;

  typedef struct packed {
    logic                 mode;
    logic [TYPE_BITS-1:0] msg_type;
    logic [31:0]          msg_time;
    logic [31:0]          now;
    logic [BODY_BITS-1:0] payload;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [TYPE_BITS-1:0] out_type;
    logic [31:0]          out_time;
    logic [BODY_BITS-1:0] out_payload;
    logic                 full_drop;
    logic [7:0]           entries_left;
  } out_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0] typ;
    logic [31:0]          sent;
    logic [BODY_BITS-1:0] body;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ARR,
    S_REQ,
    S_CNT_RD,
    S_CNT_TY,
    S_CNT_WR,
    S_PRG_RD,
    S_PRG_WR,
    S_SCN_RD,
    S_SCN_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic arrive;
    logic sweep;
    logic cnt_upd;
    logic cnt_done;
    logic prg_upd;
    logic prg_done;
    logic scn_upd;
    logic scn_done;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic purge_need;
    logic sweep_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/tmsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module tmsr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/tmsr_ctrl.sv =====
// Controller state machine of the mailbox: sequences the reset sweep and the arrival, count,
// purge and scan passes. Depends on tmsr_pkg.
`default_nettype none
module tmsr_ctrl
  import tmsr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_mode_i,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (in_mode_i == MODE_REQUEST) ? S_REQ : S_ARR;
        end
      end
      S_ARR: begin
        cmd_o.arrive = 1'b1;
        state_d = S_OUT;
      end
      S_REQ: begin
        state_d = sts_i.purge_need ? S_CNT_RD : S_SCN_RD;
      end
      S_CNT_RD: begin
        if (sts_i.idx_end) begin
          cmd_o.cnt_done = 1'b1;
          state_d = S_PRG_RD;
        end else begin
          state_d = S_CNT_TY;
        end
      end
      S_CNT_TY: state_d = S_CNT_WR;
      S_CNT_WR: begin
        cmd_o.cnt_upd = 1'b1;
        state_d = S_CNT_RD;
      end
      S_PRG_RD: begin
        if (sts_i.idx_end) begin
          cmd_o.prg_done = 1'b1;
          state_d = S_SCN_RD;
        end else begin
          state_d = S_PRG_WR;
        end
      end
      S_PRG_WR: begin
        cmd_o.prg_upd = 1'b1;
        state_d = S_PRG_RD;
      end
      S_SCN_RD: begin
        if (sts_i.idx_end) begin
          cmd_o.scn_done = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_SCN_WR;
        end
      end
      S_SCN_WR: begin
        cmd_o.scn_upd = 1'b1;
        state_d = S_SCN_RD;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tmsr_dp.sv =====
// Datapath of the mailbox: entry store, per-type count store, indexes,
// configuration registers and result registers. Depends on tmsr_pkg, tmsr_ram.
`default_nettype none
module tmsr_dp
  import tmsr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire in_t         in_i,
  output out_t             out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  in_t                  item_q;
  logic [CNT_W-1:0]     count_q, idx_q, kept_q, best_cnt_q;
  logic [TYPE_BITS-1:0] best_type_q, sweep_q;
  logic                 hit_q, flush_q;
  logic [7:0]           thr_q;
  logic [15:0]          age_q;
  logic                 found_q, full_q;
  entry_t               res_q, rd_ent, wr_ent;

  logic                 e_we;
  logic [AW-1:0]        e_waddr;
  logic                 c_we;
  logic [TYPE_BITS-1:0] c_waddr;
  logic [CNT_W-1:0]     c_wdata, c_rdata, c_inc;
  logic                 arr_fresh, ent_fresh, match, room, keep_scan;

  tmsr_ram #(.Width(ENTRY_W), .Depth(DEPTH)) u_entries (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (wr_ent),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_ent)
  );

  tmsr_ram #(.Width(CNT_W), .Depth(NTYPES)) u_counts (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (rd_ent.typ),
    .rdata_o (c_rdata)
  );

  assign arr_fresh = {1'b0, item_q.now} <= ({1'b0, item_q.msg_time} + 33'(age_q));
  assign ent_fresh = {1'b0, item_q.now} <= ({1'b0, rd_ent.sent} + 33'(age_q));
  assign match     = !hit_q && (rd_ent.typ == item_q.msg_type);
  assign room      = count_q != CNT_W'(DEPTH);
  assign keep_scan = !match && (hit_q || ent_fresh);
  assign c_inc     = c_rdata + CNT_W'(1);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = kept_q[AW-1:0];
    wr_ent  = rd_ent;
    if (cmd_i.arrive) begin
      e_we    = arr_fresh && !flush_q && room;
      e_waddr = count_q[AW-1:0];
      wr_ent  = '{typ: item_q.msg_type, sent: item_q.msg_time, body: item_q.payload};
    end else if (cmd_i.prg_upd) begin
      e_we = rd_ent.typ != best_type_q;
    end else if (cmd_i.scn_upd) begin
      e_we = keep_scan;
    end
  end

  always_comb begin
    c_we    = cmd_i.sweep || cmd_i.cnt_upd || cmd_i.prg_upd;
    c_waddr = cmd_i.sweep ? sweep_q : rd_ent.typ;
    c_wdata = cmd_i.cnt_upd ? c_inc : '0;
  end

  assign sts_o.idx_end    = idx_q == count_q;
  assign sts_o.purge_need = CMP_W'(count_q) >= CMP_W'(thr_q);
  assign sts_o.sweep_last = &sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sweep_q <= '0;
      flush_q <= 1'b1;
      thr_q   <= THRESHOLD_RESET;
      age_q   <= MAX_AGE_RESET;
    end else begin
      if (cmd_i.sweep) sweep_q <= sweep_q + TYPE_BITS'(1);
      if (cmd_i.arrive && arr_fresh && !flush_q && room) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.prg_done || cmd_i.scn_done) count_q <= kept_q;
      if (cmd_i.scn_done) flush_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_THRESHOLD: thr_q   <= cfg_data_i[7:0];
          REG_MAX_AGE:   age_q   <= cfg_data_i;
          REG_FLUSH:     flush_q <= cfg_data_i[0];
          REG_NONE:      ;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q      <= in_i;
      idx_q       <= '0;
      kept_q      <= '0;
      best_cnt_q  <= '0;
      best_type_q <= '0;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      full_q      <= 1'b0;
      res_q       <= '0;
    end
    if (cmd_i.arrive && arr_fresh && !flush_q) begin
      found_q <= room;
      full_q  <= !room;
    end
    if (cmd_i.cnt_upd) begin
      idx_q <= idx_q + CNT_W'(1);
      if (c_inc > best_cnt_q) begin
        best_cnt_q  <= c_inc;
        best_type_q <= rd_ent.typ;
      end
    end
    if (cmd_i.cnt_done || cmd_i.prg_done) idx_q <= '0;
    if (cmd_i.prg_done) kept_q <= '0;
    if (cmd_i.prg_upd) begin
      idx_q <= idx_q + CNT_W'(1);
      if (rd_ent.typ != best_type_q) kept_q <= kept_q + CNT_W'(1);
    end
    if (cmd_i.scn_upd) begin
      idx_q <= idx_q + CNT_W'(1);
      if (keep_scan) kept_q <= kept_q + CNT_W'(1);
      if (match) begin
        hit_q   <= 1'b1;
        found_q <= 1'b1;
        res_q   <= rd_ent;
      end
    end
  end

  assign out_o = '{found: found_q, out_type: res_q.typ, out_time: res_q.sent,
                   out_payload: res_q.body, full_drop: full_q,
                   entries_left: 8'(count_q)};

endmodule
`default_nettype wire

// ===== rtl/typed_mailbox_selective_receive_core.sv =====
// Top level of the typed mailbox with selective receive.
// An arrival is stored or dropped and its result then offered; a request runs a scan pass,
// preceded by a count pass and a purge pass when the stored count reaches the threshold.
// One request at a time; the next is taken once the result has been taken.
// After reset all 4096 entries of the per-type count store are swept, with input stalled.
// Depends on tmsr_pkg, tmsr_ctrl, tmsr_dp.
`default_nettype none
module typed_mailbox_selective_receive_core
  import tmsr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tmsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_mode_i   (in_i.mode),
    .out_stall_i (out_stall),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid)
  );

  tmsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
`default_nettype wire

// ===== rtl/tmsr_chk.sv =====
// Port-level checker for the mailbox, bound to the top level.
// Depends on tmsr_pkg.
`default_nettype none
module tmsr_chk
  import tmsr_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> in_stall) else $error("request taken while busy");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input open while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_o)) else $error("result changed");

  a_found_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_o.found && out_o.full_drop)) else $error("stored and dropped");

  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.found |-> out_o.out_type == '0 && out_o.out_time == '0
    && out_o.out_payload == '0) else $error("fields set without a match");

endmodule

bind typed_mailbox_selective_receive_core tmsr_chk u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_o     (out_o)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the typed mailbox with selective receive: a queue-fed driver, a
// monitor that predicts each result from its own mailbox model, and phased settings.
// Depends on tmsr_pkg and typed_mailbox_selective_receive_core.
`default_nettype none
module tb;
  import tmsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  typed_mailbox_selective_receive_core DUT (.*);

  always #5 clk_i = ~clk_i;

  in_t pending_items[$];
  out_t expected_results[$];
  logic in_took = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int errors = 0;

  entry_t box[DEPTH];
  int box_count = 0;
  logic flush_pend = 1'b1;
  logic [7:0] thr = THRESHOLD_RESET;
  logic [15:0] age_limit = MAX_AGE_RESET;
  logic [31:0] tnow = 32'd1000;

  function automatic logic fresh(logic [31:0] sent, logic [31:0] now);
    return {1'b0, now} <= {1'b0, sent} + {17'b0, age_limit};
  endfunction

  function automatic void purge_top_type();
    logic [TYPE_BITS-1:0] best_type;
    int best_n;
    int run;
    int kept;
    best_type = '0;
    best_n = 0;
    kept = 0;
    for (int i = 0; i < box_count; i++) begin
      run = 0;
      for (int k = 0; k <= i; k++) if (box[k].typ == box[i].typ) run++;
      if (run > best_n) begin
        best_n = run;
        best_type = box[i].typ;
      end
    end
    for (int i = 0; i < box_count; i++) begin
      if (box[i].typ != best_type) begin
        box[kept] = box[i];
        kept++;
      end
    end
    box_count = kept;
  endfunction

  function automatic out_t mailbox_step(in_t it);
    out_t r;
    int kept;
    logic hit;
    r = '0;
    if (it.mode == MODE_ARRIVE) begin
      if (fresh(it.msg_time, it.now) && !flush_pend) begin
        if (box_count >= DEPTH) begin
          r.full_drop = 1'b1;
        end else begin
          box[box_count] = '{typ: it.msg_type, sent: it.msg_time, body: it.payload};
          box_count++;
          r.found = 1'b1;
        end
      end
    end else begin
      if (box_count >= thr) purge_top_type();
      kept = 0;
      hit = 1'b0;
      for (int i = 0; i < box_count; i++) begin
        if (!hit && box[i].typ == it.msg_type) begin
          hit = 1'b1;
          r.found = 1'b1;
          r.out_type = box[i].typ;
          r.out_time = box[i].sent;
          r.out_payload = box[i].body;
        end else if (hit || fresh(box[i].sent, it.now)) begin
          box[kept] = box[i];
          kept++;
        end
      end
      box_count = kept;
      flush_pend = 1'b0;
    end
    r.entries_left = box_count[7:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h got %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_i <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t exp_r;
    in_took <= in_valid && !in_stall;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none got %0h", $realtime, out_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("found", exp_r.found, out_o.found);
        check_field("out_type", exp_r.out_type, out_o.out_type);
        check_field("out_time", exp_r.out_time, out_o.out_time);
        check_field("out_payload", exp_r.out_payload, out_o.out_payload);
        check_field("full_drop", exp_r.full_drop, out_o.full_drop);
        check_field("entries_left", exp_r.entries_left, out_o.entries_left);
      end
    end
    if (rst_ni && in_valid && !in_stall) expected_results.push_back(mailbox_step(in_i));
  end

  task automatic write_reg(reg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD: thr = data[7:0];
      REG_MAX_AGE: age_limit = data;
      REG_FLUSH: flush_pend = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_t mk(mode_e m, logic [TYPE_BITS-1:0] ty, logic [31:0] sent,
                             logic [31:0] now, logic [63:0] body);
    in_t it;
    it.mode = m;
    it.msg_type = ty;
    it.msg_time = sent;
    it.now = now;
    it.payload = body;
    return it;
  endfunction

  task automatic add_random(int n, int arrive_pct, int age_window);
    in_t it;
    logic [TYPE_BITS-1:0] ty;
    for (int i = 0; i < n; i++) begin
      tnow = tnow + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) ty = TYPE_BITS'($urandom_range(0, NTYPES - 1));
      else ty = TYPE_BITS'($urandom_range(0, 7));
      it = mk(($urandom_range(0, 99) < arrive_pct) ? MODE_ARRIVE : MODE_REQUEST, ty,
              tnow - $urandom_range(0, age_window), tnow,
              {$urandom(), $urandom()});
      pending_items.push_back(it);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    pending_items.push_back(mk(MODE_ARRIVE, 12'd1, 32'd1000, 32'd1000, 64'h1));
    pending_items.push_back(mk(MODE_REQUEST, 12'd5, 32'd0, 32'd1000, 64'h0));
    pending_items.push_back(mk(MODE_ARRIVE, 12'd0, 32'd1000, 32'd1000, 64'h0));
    pending_items.push_back(mk(MODE_ARRIVE, 12'hFFF, 32'd990, 32'd1000, '1));
    pending_items.push_back(mk(MODE_ARRIVE, 12'd2, 32'd989, 32'd1000, 64'h55));
    pending_items.push_back(mk(MODE_ARRIVE, 12'd3, '1, '1, 64'hA5A5_A5A5_A5A5_A5A5));
    pending_items.push_back(mk(MODE_ARRIVE, 12'd3, 32'hFFFF_FFF5, '1, 64'h5A5A));
    pending_items.push_back(mk(MODE_ARRIVE, 12'd7, 32'd1005, 32'd1005, 64'h77));
    pending_items.push_back(mk(MODE_ARRIVE, 12'd7, 32'd1005, 32'd1005, 64'h78));
    pending_items.push_back(mk(MODE_REQUEST, 12'hFFF, 32'd0, 32'd1005, 64'h0));
    pending_items.push_back(mk(MODE_REQUEST, 12'd7, 32'd0, 32'd1005, 64'h0));
    pending_items.push_back(mk(MODE_REQUEST, 12'd99, 32'd0, 32'd1016, 64'h0));
    pending_items.push_back(mk(MODE_REQUEST, 12'd3, 32'd0, 32'd0, 64'h0));
    pending_items.push_back(mk(MODE_REQUEST, 12'd3, 32'd0, '1, 64'h0));
    drain();

    write_reg(REG_THRESHOLD, 16'd128);
    write_reg(REG_MAX_AGE, 16'hFFFF);
    write_reg(REG_FLUSH, 16'd0);
    write_reg(REG_NONE, 16'hFFFF);
    send_idle_pct = 11;
    recv_idle_pct = 81;
    tnow = $urandom();
    add_random(500, 80, 70000);
    hold_left = 3000;
    drain();

    write_reg(REG_THRESHOLD, 16'hFF);
    write_reg(REG_THRESHOLD, 16'd1);
    write_reg(REG_MAX_AGE, 16'd0);
    write_reg(REG_FLUSH, 16'd1);
    send_idle_pct = 81;
    recv_idle_pct = 11;
    tnow = 32'hFFFF_FF00;
    add_random(500, 60, 1);
    drain();

    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_MAX_AGE, 16'd300);
    write_reg(REG_FLUSH, 16'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    tnow = 32'd50;
    add_random(250, 70, 400);
    drain();
    write_reg(REG_THRESHOLD, 16'd20);
    add_random(250, 65, 400);
    drain();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
